FILE: rtl/efhs_pkg.sv
`default_nettype none

package efhs_pkg;

  // Input transaction: one packet header's flow key and the next-hop count.
  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [6:0]  path_count;
  } efhs_in_t;

  // Result transaction.
  typedef struct packed {
    logic [5:0]  path_index;
    logic [31:0] hash_value;
    logic        bad_protocol;
  } efhs_out_t;

  // Control that travels alongside the hash through both pipelines.
  typedef struct packed {
    logic       proto_ok;
    logic [6:0] divisor;
  } efhs_side_t;

  // Supported protocol numbers.
  localparam logic [7:0] PROTO_TCP  = 8'h06;
  localparam logic [7:0] PROTO_UDP  = 8'h11;
  localparam logic [7:0] PROTO_ACK  = 8'hFC;
  localparam logic [7:0] PROTO_NACK = 8'hFD;

  // MurmurHash3 x86_32 constants.
  localparam logic [31:0] MM_C1      = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2      = 32'h1b873593;
  localparam logic [31:0] MM_MIX_ADD = 32'he6546b64;
  localparam logic [31:0] MM_FMIX1   = 32'h85ebca6b;
  localparam logic [31:0] MM_FMIX2   = 32'hc2b2ae35;
  localparam logic [31:0] KEY_BYTES  = 32'd12;

  // Pipeline geometry.
  localparam int HASH_STAGES    = 8;
  localparam int MOD_STAGES     = 4;
  localparam int BITS_PER_STAGE = 8;
  localparam int LATENCY        = HASH_STAGES + MOD_STAGES;

  function automatic logic [31:0] rotl15(input logic [31:0] x);
    rotl15 = {x[16:0], x[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] x);
    rotl13 = {x[18:0], x[31:19]};
  endfunction

  // One body round on the hash state: xor in the key, rotate, times five, add.
  function automatic logic [31:0] mix_h(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] x;
    x = rotl13(h ^ k);
    mix_h = x + {x[29:0], 2'b00} + MM_MIX_ADD;
  endfunction

  // Eight restoring remainder steps, dividend bits taken MSB first.
  function automatic logic [6:0] rem_step(input logic [6:0] r_in,
                                          input logic [6:0] d,
                                          input logic [7:0] bits);
    logic [7:0] t;
    logic [6:0] r;
    r = r_in;
    for (int i = 7; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
      r = t[6:0];
    end
    rem_step = r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/efhs_hash.sv
`default_nettype none

module efhs_hash (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [31:0]         word0,
  input  wire logic [31:0]         word1,
  input  wire logic [31:0]         word2,
  input  wire logic [31:0]         seed,
  input  wire efhs_pkg::efhs_side_t in_side,
  output logic                     out_valid,
  output logic [31:0]              out_hash,
  output efhs_pkg::efhs_side_t     out_side
);
  import efhs_pkg::*;

  logic [HASH_STAGES-1:0] v_r;
  efhs_side_t             side_r [HASH_STAGES];

  logic [31:0] k1_r [3];
  logic [31:0] k2_r [3];
  logic [31:0] h1_r, h2_r, f5_r, m6_r, m7_r, hash_r;
  logic [31:0] k3a_r, k3b_r, k4_r;
  logic [31:0] h3_nxt, f5_nxt, g7_nxt;

  // Valid bits and sideband advance one stage every cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[HASH_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int i = 1; i < HASH_STAGES; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  // Stage 1: first key multiply on all three words.
  always_ff @(posedge clk) begin
    k1_r[0] <= word0 * MM_C1;
    k1_r[1] <= word1 * MM_C1;
    k1_r[2] <= word2 * MM_C1;
  end

  // Stage 2: rotate and second key multiply.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      k2_r[i] <= rotl15(k1_r[i]) * MM_C2;
    end
  end

  // Stages 3 and 4: fold the first two key words into the state.
  always_ff @(posedge clk) begin
    h1_r  <= mix_h(seed, k2_r[0]);
    k3a_r <= k2_r[1];
    k3b_r <= k2_r[2];
    h2_r  <= mix_h(h1_r, k3a_r);
    k4_r  <= k3b_r;
  end

  // Stage 5: last word, length, and first finalizer shift.
  always_comb begin
    h3_nxt = mix_h(h2_r, k4_r) ^ KEY_BYTES;
    f5_nxt = h3_nxt ^ {16'h0000, h3_nxt[31:16]};
  end

  // Stages 6 to 8: finalizer multiplies and shifts.
  always_comb begin
    g7_nxt = m6_r ^ {13'h0000, m6_r[31:13]};
  end

  always_ff @(posedge clk) begin
    f5_r   <= f5_nxt;
    m6_r   <= f5_r * MM_FMIX1;
    m7_r   <= g7_nxt * MM_FMIX2;
    hash_r <= m7_r ^ {16'h0000, m7_r[31:16]};
  end

  assign out_valid = v_r[HASH_STAGES-1];
  assign out_hash  = hash_r;
  assign out_side  = side_r[HASH_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/efhs_mod.sv
`default_nettype none

module efhs_mod (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic [31:0]          in_hash,
  input  wire efhs_pkg::efhs_side_t in_side,
  output logic                      out_valid,
  output efhs_pkg::efhs_out_t       out_item
);
  import efhs_pkg::*;

  logic [MOD_STAGES-1:0] v_r;
  logic [6:0]            r_r    [MOD_STAGES];
  logic [31:0]           hash_r [MOD_STAGES];
  efhs_side_t            side_r [MOD_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[MOD_STAGES-2:0], in_valid};
    end
  end

  // Each stage retires one byte of the hash into the running remainder.
  always_ff @(posedge clk) begin
    r_r[0]    <= rem_step(7'd0, in_side.divisor,
                          in_hash[31 -: BITS_PER_STAGE]);
    hash_r[0] <= in_hash;
    side_r[0] <= in_side;
    for (int s = 1; s < MOD_STAGES; s++) begin
      r_r[s]    <= rem_step(r_r[s-1], side_r[s-1].divisor,
                            hash_r[s-1][31 - s*BITS_PER_STAGE -: BITS_PER_STAGE]);
      hash_r[s] <= hash_r[s-1];
      side_r[s] <= side_r[s-1];
    end
  end

  // A bad protocol or a zero count selects path zero.
  always_comb begin
    out_item.hash_value   = hash_r[MOD_STAGES-1];
    out_item.bad_protocol = !side_r[MOD_STAGES-1].proto_ok;
    if (side_r[MOD_STAGES-1].proto_ok && (side_r[MOD_STAGES-1].divisor != 7'd0)) begin
      out_item.path_index = r_r[MOD_STAGES-1][5:0];
    end else begin
      out_item.path_index = 6'd0;
    end
  end

  assign out_valid = v_r[MOD_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/ecmp_flow_hash_select.sv
`default_nettype none

// ECMP flow-hash path selector. One transaction may be started in every
// clock cycle: busy is never raised. Each transaction's result appears on
// out_item, marked by out_valid, once through both pipelines, in start order,
// and is held for a single cycle only; the receiver cannot stall it. The
// pipeline is 8 MurmurHash3 stages (at most one 32x32 multiply per key word
// or one mix round per stage) and a 4-stage remainder unit that retires
// eight hash bits per stage. hash_seed is written through cfg_we/cfg_wdata
// and should be changed only while no transaction is in flight.

module ecmp_flow_hash_select #(
  parameter int MAX_PATHS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire efhs_pkg::efhs_in_t  in_item,
  output logic                     out_valid,
  output efhs_pkg::efhs_out_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_wdata
);
  import efhs_pkg::*;

  logic        seed_r;
  logic [31:0] hash_seed_r;
  logic        accept;
  efhs_side_t  side;
  logic        hash_valid;
  logic [31:0] hash_value;
  efhs_side_t  hash_side;

  // Seed register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_seed_r <= '0;
    end else if (cfg_we) begin
      hash_seed_r <= cfg_wdata;
    end
  end

  // Marks that the seed was written since reset; used only by the checks below.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 1'b0;
    end else if (cfg_we) begin
      seed_r <= 1'b1;
    end
  end

  // The pipeline takes a transaction every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Protocol check and count saturation.
  always_comb begin
    side.proto_ok = in_item.protocol inside {PROTO_TCP, PROTO_UDP, PROTO_ACK, PROTO_NACK};
    if (32'(in_item.path_count) > MAX_PATHS) begin
      side.divisor = 7'(MAX_PATHS);
    end else begin
      side.divisor = in_item.path_count;
    end
  end

  efhs_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .word0    (in_item.src_ip),
    .word1    (in_item.dst_ip),
    .word2    ({in_item.dst_port, in_item.src_port}),
    .seed     (hash_seed_r),
    .in_side  (side),
    .out_valid(hash_valid),
    .out_hash (hash_value),
    .out_side (hash_side)
  );

  efhs_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (hash_valid),
    .in_hash  (hash_value),
    .in_side  (hash_side),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // Every started transaction comes out after the full latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("started transaction did not complete on time");

  // The hash stage feeds the remainder unit without loss.
  a_mod_stage: assert property (@(posedge clk) disable iff (!rst_n)
    hash_valid |-> ##MOD_STAGES out_valid)
    else $error("hash result lost in remainder unit");

  // A rejected protocol always selects path zero.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.bad_protocol) |-> (out_item.path_index == 6'd0))
    else $error("bad protocol with nonzero path index");

  // A seed write is never lost.
  a_seed: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (seed_r && (hash_seed_r == $past(cfg_wdata))))
    else $error("seed write not captured");

endmodule

`default_nettype wire

FILE: test/ecmp_flow_hash_select_test.sv
module ecmp_flow_hash_select_test;
  import efhs_pkg::*;

  localparam int MAX_PATHS   = 64;
  localparam int CYCLE_LIMIT = 100000;
  localparam int IDLE_PCT    = 29;
  localparam int PHASE_FLOWS = 166;

  // Predicts each path selection and holds the selections not yet seen at the output.
  class path_scoreboard;
    logic [31:0] seed;
    efhs_out_t   pending_paths[$];
    int          errors;
    int          flows_noted;
    int          bad_flows;
    int          results_checked;

    function new();
      seed = '0;
      errors = 0;
      flows_noted = 0;
      bad_flows = 0;
      results_checked = 0;
    endfunction

    // MurmurHash3 x86_32 over the three key words, 12 bytes long.
    function logic [31:0] flow_hash(efhs_in_t flow);
      logic [31:0] words [3];
      logic [31:0] h;
      logic [31:0] k;
      words[0] = flow.src_ip;
      words[1] = flow.dst_ip;
      words[2] = {flow.dst_port, flow.src_port};
      h = seed;
      for (int i = 0; i < 3; i++) begin
        k = words[i] * MM_C1;
        k = {k[16:0], k[31:17]};
        k = k * MM_C2;
        h = h ^ k;
        h = {h[18:0], h[31:19]};
        h = h * 32'd5 + MM_MIX_ADD;
      end
      h = h ^ KEY_BYTES;
      h = h ^ (h >> 16);
      h = h * MM_FMIX1;
      h = h ^ (h >> 13);
      h = h * MM_FMIX2;
      h = h ^ (h >> 16);
      return h;
    endfunction

    // Path choice: hash modulo the saturated hop count, zero on error or no hops.
    function efhs_out_t select_path(efhs_in_t flow);
      logic [6:0] hops;
      logic       supported;
      efhs_out_t  sel;
      supported = (flow.protocol == PROTO_TCP) || (flow.protocol == PROTO_UDP) ||
                  (flow.protocol == PROTO_ACK) || (flow.protocol == PROTO_NACK);
      hops = (flow.path_count > 7'(MAX_PATHS)) ? 7'(MAX_PATHS) : flow.path_count;
      sel.hash_value = flow_hash(flow);
      sel.path_index = (supported && hops != 0) ? 6'(sel.hash_value % hops) : '0;
      sel.bad_protocol = !supported;
      return sel;
    endfunction

    function void note_input(efhs_in_t flow);
      efhs_out_t sel;
      sel = select_path(flow);
      if (sel.bad_protocol) begin
        bad_flows++;
      end
      flows_noted++;
      pending_paths = {pending_paths, sel};
    endfunction

    function void check_result(efhs_out_t got);
      efhs_out_t want;
      if (pending_paths.size() == 0) begin
        $error("result with no transaction outstanding: path_index %0d hash_value %h",
               got.path_index, got.hash_value);
        errors++;
        return;
      end
      want = pending_paths.pop_front();
      results_checked++;
      if (got.path_index !== want.path_index) begin
        $error("path_index: expected %0d, got %0d", want.path_index, got.path_index);
        errors++;
      end
      if (got.hash_value !== want.hash_value) begin
        $error("hash_value: expected %h, got %h", want.hash_value, got.hash_value);
        errors++;
      end
      if (got.bad_protocol !== want.bad_protocol) begin
        $error("bad_protocol: expected %0b, got %0b", want.bad_protocol, got.bad_protocol);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  efhs_in_t    in_item;
  logic        out_valid;
  efhs_out_t   out_item;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  path_scoreboard flows = new();
  int             cycle_count = 0;
  int             seeds_used = 0;
  bit             idling = 1'b1;

  ecmp_flow_hash_select #(
    .MAX_PATHS(MAX_PATHS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ecmp_flow_hash_select_test failed");
    $finish;
  end

  // Record accepted transactions and check every strobed result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        flows.note_input(in_item);
      end
      if (out_valid) begin
        flows.check_result(out_item);
      end
    end
  end

  function automatic efhs_in_t make_flow(logic [31:0] sip, logic [31:0] dip,
                                         logic [7:0] proto, logic [15:0] sport,
                                         logic [15:0] dport, logic [6:0] hops);
    efhs_in_t flow;
    flow.src_ip = sip;
    flow.dst_ip = dip;
    flow.protocol = proto;
    flow.src_port = sport;
    flow.dst_port = dport;
    flow.path_count = hops;
    return flow;
  endfunction

  // Mostly supported protocols and in-range hop counts, with some of everything else.
  function automatic efhs_in_t random_flow();
    logic [7:0] protocols [4];
    logic [7:0] proto;
    logic [6:0] hops;
    int         pick;
    protocols = '{PROTO_TCP, PROTO_UDP, PROTO_ACK, PROTO_NACK};
    proto = (($urandom_range(9)) < 7) ? protocols[$urandom_range(3)] : 8'($urandom);
    pick = $urandom_range(19);
    if (pick == 0) begin
      hops = '0;
    end else if (pick == 1) begin
      hops = 7'($urandom_range(MAX_PATHS + 1, 127));
    end else if (pick == 2) begin
      hops = 7'(MAX_PATHS);
    end else begin
      hops = 7'($urandom_range(1, MAX_PATHS - 1));
    end
    return make_flow($urandom, $urandom, proto, 16'($urandom), 16'($urandom), hops);
  endfunction

  // Present one transaction, then idle for a random run of cycles now and then.
  task automatic send_flow(input efhs_in_t flow);
    logic [127:0] noise;
    in_item <= flow;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (idling && $urandom_range(99) < IDLE_PCT) begin
      noise = {$urandom, $urandom, $urandom, $urandom};
      start <= 1'b0;
      in_item <= noise[$bits(efhs_in_t)-1:0];
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
  endtask

  // Stop sending and let every outstanding transaction come back.
  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (flows.pending_paths.size() != 0) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    flows.seed = value;
    seeds_used++;
  endtask

  initial begin
    logic [31:0] phase_seeds [5];

    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed flows under the reset seed: field extremes, every protocol,
    // its neighbors, zero hops and saturating hop counts.
    seeds_used = 1;
    send_flow(make_flow('0, '0, PROTO_TCP, '0, '0, 7'd1));
    send_flow(make_flow('1, '1, PROTO_UDP, '1, '1, 7'd64));
    send_flow(make_flow('1, '0, PROTO_ACK, 16'h1234, 16'h4321, 7'd65));
    send_flow(make_flow('0, '1, PROTO_NACK, '1, '0, 7'd127));
    send_flow(make_flow(32'h0a000001, 32'h0a000002, 8'h00, 16'd80, 16'd443, 7'd5));
    send_flow(make_flow('1, '1, 8'hFF, '1, '1, 7'd127));
    send_flow(make_flow(32'hc0a80001, 32'hc0a80002, 8'h07, 16'd1, 16'd2, 7'd64));
    send_flow(make_flow(32'hc0a80003, 32'hc0a80004, 8'h05, 16'd3, 16'd4, 7'd7));
    send_flow(make_flow(32'h01020304, 32'h05060708, 8'h10, 16'd5, 16'd6, 7'd9));
    send_flow(make_flow(32'h01020305, 32'h05060709, 8'h12, 16'd7, 16'd8, 7'd10));
    send_flow(make_flow(32'h11111111, 32'h22222222, 8'hFB, 16'd9, 16'd10, 7'd11));
    send_flow(make_flow(32'h33333333, 32'h44444444, 8'hFE, 16'd11, 16'd12, 7'd12));
    send_flow(make_flow(32'h55555555, 32'haaaaaaaa, PROTO_TCP, 16'h5555, 16'haaaa, 7'd0));
    send_flow(make_flow('1, '1, PROTO_UDP, '1, '1, 7'd0));
    send_flow(make_flow(32'hdeadbeef, 32'hcafef00d, PROTO_TCP, 16'd1024, 16'd80, 7'd63));
    send_flow(make_flow(32'h80000000, 32'h00000001, PROTO_TCP, 16'h8000, 16'h0001, 7'd2));
    send_flow(make_flow(32'h7fffffff, 32'hfffffffe, PROTO_UDP, '1, '0, 7'd3));
    send_flow(make_flow(32'hfffffffe, 32'h7fffffff, PROTO_UDP, '0, '1, 7'd4));
    send_flow(make_flow($urandom, $urandom, PROTO_ACK, 16'($urandom), 16'($urandom), 7'd3));
    send_flow(make_flow($urandom, $urandom, 8'h42, 16'($urandom), 16'($urandom), 7'd0));

    // Random phases, each under its own seed and started only once the block is empty.
    phase_seeds = '{32'hFFFFFFFF, $urandom, 32'h00000000, 32'h80000001, $urandom};
    foreach (phase_seeds[p]) begin
      wait_for_drain();
      write_seed(phase_seeds[p]);
      idling = (p != 1);
      repeat (PHASE_FLOWS) send_flow(random_flow());
    end

    wait_for_drain();
    repeat (LATENCY + 4) @(posedge clk);
    if (flows.pending_paths.size() != 0) begin
      $error("%0d transactions never produced a result", flows.pending_paths.size());
      flows.errors++;
    end

    $display("Covered %0d flows, %0d of them with an unsupported protocol, under %0d seeds;",
             flows.flows_noted, flows.bad_flows, seeds_used);
    $display("%0d results checked, %0d mismatches.", flows.results_checked, flows.errors);
    if (flows.errors == 0) begin
      $display("ecmp_flow_hash_select_test passed");
    end else begin
      $display("ecmp_flow_hash_select_test failed");
    end
    $finish;
  end

endmodule
